// File: sv/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the text encoding sniffer
// Encoding codes, byte-order-mark bytes and the per-buffer control state.
// ----------------------------------------------------------------------------
package tes_pkg;

  typedef enum logic [2:0] {
    ENC_ASCII   = 3'd0,
    ENC_BINARY  = 3'd1,
    ENC_UTF8    = 3'd2,
    ENC_UCS2_LE = 3'd3,
    ENC_UCS2_BE = 3'd4,
    ENC_UCS4_LE = 3'd5,
    ENC_UCS4_BE = 3'd6
  } tes_enc_t;

  localparam logic [7:0] BYTE_FE  = 8'hFE;
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_EF  = 8'hEF;
  localparam logic [7:0] BYTE_BB  = 8'hBB;
  localparam logic [7:0] BYTE_BF  = 8'hBF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_SP  = 8'h20;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Byte position saturates here: four means four or more bytes seen.
  localparam logic [2:0] POS_FULL = 3'd4;

  // Per-buffer control state, excluding the counters.
  typedef struct packed {
    logic [2:0]      byte_position;
    logic [2:0][7:0] prefix_bytes;
    logic            tail_zero;
    logic            tail_feff;
    logic [1:0]      cont_needed;
    logic [1:0]      cont_seen;
  } tes_ctl_t;

endpackage

// File: sv/tes_scan.sv
// ----------------------------------------------------------------------------
// tes_scan: next-state logic for one byte
// Tracks UTF-8 sequences, the buffer prefix and the three saturating counters.
// ----------------------------------------------------------------------------
module tes_scan import tes_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  tes_ctl_t               ctl,
  input  logic [COUNT_WIDTH-1:0] seq_cnt,
  input  logic [COUNT_WIDTH-1:0] high_cnt,
  input  logic [COUNT_WIDTH-1:0] ctrl_cnt,
  output tes_ctl_t               ctl_upd,
  output logic [COUNT_WIDTH-1:0] seq_upd,
  output logic [COUNT_WIDTH-1:0] high_upd,
  output logic [COUNT_WIDTH-1:0] ctrl_upd
);

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [1:0] inc);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {{(COUNT_WIDTH-1){1'b0}}, inc};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  logic       open_seq, taken, complete, brk, is_ctrl, high_scan;
  logic [1:0] seen_inc, lead_need, needed_n, seen_n, high_inc;

  always_comb begin
    open_seq  = (ctl.cont_needed != 2'd0);
    taken     = open_seq && (data_byte[7:6] == 2'b10);
    brk       = open_seq && !taken;
    seen_inc  = ctl.cont_seen + 2'd1;
    complete  = taken && (seen_inc == ctl.cont_needed);
    high_scan = !taken && data_byte[7];

    unique if (data_byte[7:5] == 3'b110)  lead_need = 2'd1;
    else if (data_byte[7:4] == 4'b1110)   lead_need = 2'd2;
    else if (data_byte[7:3] == 5'b11110)  lead_need = 2'd3;
    else                                  lead_need = 2'd0;

    if (taken) begin
      needed_n = complete ? 2'd0 : ctl.cont_needed;
      seen_n   = complete ? 2'd0 : seen_inc;
    end else begin
      needed_n = data_byte[7] ? lead_need : 2'd0;
      seen_n   = 2'd0;
    end

    is_ctrl = !data_byte[7] && (data_byte < BYTE_SP || data_byte == BYTE_DEL) &&
              data_byte != BYTE_CR && data_byte != BYTE_LF && data_byte != BYTE_TAB;

    // A broken sequence returns its accepted continuations to the high-bit
    // count; an unfinished one does the same at the end of the buffer.
    high_inc = (brk ? ctl.cont_seen : 2'd0) + {1'b0, high_scan} +
               ((last_byte && needed_n != 2'd0) ? seen_n : 2'd0);

    seq_upd  = sat_add(seq_cnt, {1'b0, complete});
    high_upd = sat_add(high_cnt, high_inc);
    ctrl_upd = sat_add(ctrl_cnt, {1'b0, !taken && is_ctrl});

    ctl_upd             = ctl;
    ctl_upd.cont_needed = needed_n;
    ctl_upd.cont_seen   = seen_n;
    if (ctl.byte_position < 3'd3) begin
      ctl_upd.prefix_bytes[ctl.byte_position[1:0]] = data_byte;
    end else if (ctl.byte_position == 3'd3) begin
      ctl_upd.tail_zero = (ctl.prefix_bytes[2] == BYTE_00) && (data_byte == BYTE_00);
      ctl_upd.tail_feff = (ctl.prefix_bytes[2] == BYTE_FE) && (data_byte == BYTE_FF);
    end
    if (ctl.byte_position < POS_FULL) begin
      ctl_upd.byte_position = ctl.byte_position + 3'd1;
    end
  end

endmodule

// File: sv/tes_decide.sv
// ----------------------------------------------------------------------------
// tes_decide: final encoding decision
// Byte-order marks first, then the UTF-8 / binary / ASCII heuristic.
// ----------------------------------------------------------------------------
module tes_decide import tes_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  tes_ctl_t               ctl,
  input  logic [COUNT_WIDTH-1:0] seq_cnt,
  input  logic [COUNT_WIDTH-1:0] high_cnt,
  input  logic [COUNT_WIDTH-1:0] ctrl_cnt,
  output tes_enc_t               encoding
);

  logic [7:0] d0, d1, d2;
  logic       has4, has3;

  always_comb begin
    d0   = ctl.prefix_bytes[0];
    d1   = ctl.prefix_bytes[1];
    d2   = ctl.prefix_bytes[2];
    has4 = (ctl.byte_position >= POS_FULL);
    has3 = (ctl.byte_position >= 3'd3);

    priority if (ctl.byte_position < 3'd2) begin
      encoding = ENC_ASCII;
    end else if (d0 == BYTE_FE && d1 == BYTE_FF) begin
      encoding = (has4 && ctl.tail_zero) ? ENC_UCS4_BE : ENC_UCS2_BE;
    end else if (d0 == BYTE_FF && d1 == BYTE_FE) begin
      encoding = (has4 && ctl.tail_zero) ? ENC_UCS4_LE : ENC_UCS2_LE;
    end else if (d0 == BYTE_00 && d1 == BYTE_00) begin
      encoding = (has4 && ctl.tail_feff) ? ENC_UCS4_BE : ENC_BINARY;
    end else if (d0 == BYTE_EF) begin
      encoding = (has3 && d1 == BYTE_BB && d2 == BYTE_BF) ? ENC_UTF8 : ENC_BINARY;
    end else if (seq_cnt != '0 && seq_cnt >= high_cnt && ctrl_cnt == '0) begin
      encoding = ENC_UTF8;
    end else if (ctrl_cnt != '0 || high_cnt != '0) begin
      encoding = ENC_BINARY;
    end else begin
      encoding = ENC_ASCII;
    end
  end

endmodule

// File: sv/text_encoding_sniffer_unit.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_unit: byte-stream text encoding classifier
// Detects byte-order marks and scores UTF-8 structure over a whole buffer.
// ----------------------------------------------------------------------------
// Usage: send a buffer one byte per transaction on the in_ channel, with
// in_tlast high on its final byte. Only that final byte produces a
// transaction on the out_ channel, carrying the encoding code and the three
// scan counters; the other bytes produce nothing and only update state.
// Path: a byte is held in an input register, and the result of a last byte is
// captured in the output register as that byte leaves the input register,
// which raises out_tvalid.
// Throughput: one byte per cycle when not stalled. The per-byte update is a
// set of small compares and one saturating increment per counter, so the input
// register advances every cycle while the output register is free.
// Stalls: a finished result waits in the output register while further bytes
// of the next buffer keep flowing; only a second last byte that meets a full,
// stalled output register holds the input register and drops in_tready.
// Reset: rst_n (synchronous, active low) empties both registers and returns
// the scan state to its initial values. After each last byte the scan state
// also returns to those values, ready for the next buffer.
// ----------------------------------------------------------------------------
module text_encoding_sniffer_unit import tes_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] encoding, [34:3] utf8_sequences, [66:35] high_bit_bytes,
  // [98:67] control_bytes, [103:99] zero
  output logic [103:0] out_tdata
);

  // Input register.
  logic       s0_valid_r, s0_valid_nxt;
  logic [7:0] s0_byte_r;
  logic       s0_last_r;
  logic       s0_fire;

  // Scan state.
  tes_ctl_t               ctl_r, ctl_nxt, ctl_upd;
  logic [COUNT_WIDTH-1:0] seq_cnt_r, seq_cnt_nxt, seq_upd;
  logic [COUNT_WIDTH-1:0] high_cnt_r, high_cnt_nxt, high_upd;
  logic [COUNT_WIDTH-1:0] ctrl_cnt_r, ctrl_cnt_nxt, ctrl_upd;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  enc_r;
  logic [31:0] seq_out_r, high_out_r, ctrl_out_r;

  tes_enc_t    enc_dec;
  logic [31:0] seq_fld, high_fld, ctrl_fld;

  // A non-last byte never needs the output register, so it always moves on.
  assign s0_fire   = s0_valid_r && (!s0_last_r || !out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || s0_fire;

  tes_scan #(.COUNT_WIDTH(COUNT_WIDTH)) u_scan (
    .data_byte (s0_byte_r),
    .last_byte (s0_last_r),
    .ctl       (ctl_r),
    .seq_cnt   (seq_cnt_r),
    .high_cnt  (high_cnt_r),
    .ctrl_cnt  (ctrl_cnt_r),
    .ctl_upd   (ctl_upd),
    .seq_upd   (seq_upd),
    .high_upd  (high_upd),
    .ctrl_upd  (ctrl_upd)
  );

  tes_decide #(.COUNT_WIDTH(COUNT_WIDTH)) u_decide (
    .ctl      (ctl_upd),
    .seq_cnt  (seq_upd),
    .high_cnt (high_upd),
    .ctrl_cnt (ctrl_upd),
    .encoding (enc_dec)
  );

  // Counters narrower than the field are zero-extended; wider ones clip.
  generate
    if (COUNT_WIDTH > 32) begin : g_clip
      assign seq_fld  = (|seq_upd[COUNT_WIDTH-1:32])  ? 32'hFFFF_FFFF : seq_upd[31:0];
      assign high_fld = (|high_upd[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : high_upd[31:0];
      assign ctrl_fld = (|ctrl_upd[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : ctrl_upd[31:0];
    end else if (COUNT_WIDTH == 32) begin : g_same
      assign seq_fld  = seq_upd;
      assign high_fld = high_upd;
      assign ctrl_fld = ctrl_upd;
    end else begin : g_extend
      assign seq_fld  = {{(32-COUNT_WIDTH){1'b0}}, seq_upd};
      assign high_fld = {{(32-COUNT_WIDTH){1'b0}}, high_upd};
      assign ctrl_fld = {{(32-COUNT_WIDTH){1'b0}}, ctrl_upd};
    end
  endgenerate

  always_comb begin
    s0_valid_nxt = in_tready ? in_tvalid : s0_valid_r;

    ctl_nxt      = ctl_r;
    seq_cnt_nxt  = seq_cnt_r;
    high_cnt_nxt = high_cnt_r;
    ctrl_cnt_nxt = ctrl_cnt_r;
    if (s0_fire) begin
      // The last byte closes the buffer and clears the scan state.
      ctl_nxt      = s0_last_r ? '0 : ctl_upd;
      seq_cnt_nxt  = s0_last_r ? '0 : seq_upd;
      high_cnt_nxt = s0_last_r ? '0 : high_upd;
      ctrl_cnt_nxt = s0_last_r ? '0 : ctrl_upd;
    end

    if (s0_fire && s0_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
      seq_cnt_r   <= '0;
      high_cnt_r  <= '0;
      ctrl_cnt_r  <= '0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      ctl_r       <= ctl_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      high_cnt_r  <= high_cnt_nxt;
      ctrl_cnt_r  <= ctrl_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s0_byte_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
    if (s0_fire && s0_last_r) begin
      enc_r      <= enc_dec;
      seq_out_r  <= seq_fld;
      high_out_r <= high_fld;
      ctrl_out_r <= ctrl_fld;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, ctrl_out_r, high_out_r, seq_out_r, enc_r};

  // A result only appears after the last byte of a buffer was processed.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s0_fire && s0_last_r))
    else $error("result raised without a processed last byte");

  // Closing a buffer leaves the scan state at its initial values.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_last_r) |=> (ctl_r == '0 && seq_cnt_r == '0 &&
                                high_cnt_r == '0 && ctrl_cnt_r == '0))
    else $error("scan state not cleared after last byte");

  // An open sequence has always accepted fewer continuations than it needs.
  a_seq_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.cont_seen < ctl_r.cont_needed) ||
    (ctl_r.cont_needed == 2'd0 && ctl_r.cont_seen == 2'd0))
    else $error("continuation tracking out of range");

  // The position counter never passes its saturation point.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.byte_position <= POS_FULL)
    else $error("byte position beyond saturation");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for text_encoding_sniffer_unit
// Buffers go in byte by byte on the in_ stream. A model of the scan state
// predicts the one result that each buffer's last byte produces, and every
// out_ transaction is checked field by field against the oldest prediction.
// Directed buffers cover every encoding code and the broken, unfinished and
// control-byte cases. Random buffers then mix byte-order marks with tails,
// UTF-8 text and raw noise under four sender-idle and receiver-stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import tes_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] bytes_t [$];

  typedef struct packed {
    tes_enc_t    enc;
    logic [31:0] seqs;
    logic [31:0] highs;
    logic [31:0] ctls;
  } sniff_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [103:0] out_tdata;

  text_encoding_sniffer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Scan state of the model.
  logic [2:0]  pos;
  logic [7:0]  head [0:2];
  logic        tail_zero;
  logic        tail_feff;
  logic [1:0]  seq_need;
  logic [1:0]  seq_seen;
  logic [31:0] n_seqs;
  logic [31:0] n_high;
  logic [31:0] n_ctl;

  sniff_result_t results_due [$];
  sniff_result_t want;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int buffers_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int enc_seen [0:6] = '{default: 0};

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_scan();
    pos = 3'd0;
    head[0] = BYTE_00;
    head[1] = BYTE_00;
    head[2] = BYTE_00;
    tail_zero = 1'b0;
    tail_feff = 1'b0;
    seq_need = 2'd0;
    seq_seen = 2'd0;
    n_seqs = 32'd0;
    n_high = 32'd0;
    n_ctl = 32'd0;
  endtask

  function automatic tes_enc_t classify();
    if (pos < 3'd2) return ENC_ASCII;
    if (head[0] == BYTE_FE && head[1] == BYTE_FF)
      return (pos >= POS_FULL && tail_zero) ? ENC_UCS4_BE : ENC_UCS2_BE;
    if (head[0] == BYTE_FF && head[1] == BYTE_FE)
      return (pos >= POS_FULL && tail_zero) ? ENC_UCS4_LE : ENC_UCS2_LE;
    if (head[0] == BYTE_00 && head[1] == BYTE_00)
      return (pos >= POS_FULL && tail_feff) ? ENC_UCS4_BE : ENC_BINARY;
    if (head[0] == BYTE_EF)
      return (pos >= 3'd3 && head[1] == BYTE_BB && head[2] == BYTE_BF) ? ENC_UTF8 : ENC_BINARY;
    if (n_seqs != 0 && n_seqs >= n_high && n_ctl == 0) return ENC_UTF8;
    if (n_ctl != 0 || n_high != 0) return ENC_BINARY;
    return ENC_ASCII;
  endfunction

  // Advances the model by one accepted byte; the last byte of a buffer
  // queues the expected result and clears the scan state.
  task automatic track_byte(input logic [7:0] b, input logic last);
    sniff_result_t r;
    logic taken;
    taken = 1'b0;
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        taken = 1'b1;
        seq_seen = seq_seen + 2'd1;
        if (seq_seen >= seq_need) begin
          n_seqs = sat_add(n_seqs, 32'd1);
          seq_need = 2'd0;
          seq_seen = 2'd0;
        end
      end else begin
        // The sequence broke: its continuation bytes count as plain high bytes.
        n_high = sat_add(n_high, {30'd0, seq_seen});
        seq_need = 2'd0;
        seq_seen = 2'd0;
      end
    end
    if (!taken) begin
      if (b[7]) begin
        n_high = sat_add(n_high, 32'd1);
        if (b[7:5] == 3'b110) seq_need = 2'd1;
        else if (b[7:4] == 4'b1110) seq_need = 2'd2;
        else if (b[7:3] == 5'b11110) seq_need = 2'd3;
        seq_seen = 2'd0;
      end else if ((b < BYTE_SP || b == BYTE_DEL) && b != BYTE_CR && b != BYTE_LF &&
                   b != BYTE_TAB) begin
        n_ctl = sat_add(n_ctl, 32'd1);
      end
    end
    if (pos < 3'd3) begin
      head[pos] = b;
    end else if (pos == 3'd3) begin
      tail_zero = (head[2] == BYTE_00 && b == BYTE_00);
      tail_feff = (head[2] == BYTE_FE && b == BYTE_FF);
    end
    if (pos < POS_FULL) pos = pos + 3'd1;
    if (last) begin
      if (seq_need != 2'd0) n_high = sat_add(n_high, {30'd0, seq_seen});
      r.enc = classify();
      r.seqs = n_seqs;
      r.highs = n_high;
      r.ctls = n_ctl;
      results_due.push_back(r);
      enc_seen[r.enc] = enc_seen[r.enc] + 1;
      clear_scan();
    end
  endtask

  // Predicts from accepted input transactions and checks each accepted result;
  // the receiver's ready is redrawn every cycle.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) track_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (out_tdata[2:0] !== want.enc) begin
          $error("encoding: expected %0d, got %0d", want.enc, out_tdata[2:0]);
          mismatch_count++;
        end
        if (out_tdata[34:3] !== want.seqs) begin
          $error("utf8_sequences: expected %0d, got %0d", want.seqs, out_tdata[34:3]);
          mismatch_count++;
        end
        if (out_tdata[66:35] !== want.highs) begin
          $error("high_bit_bytes: expected %0d, got %0d", want.highs, out_tdata[66:35]);
          mismatch_count++;
        end
        if (out_tdata[98:67] !== want.ctls) begin
          $error("control_bytes: expected %0d, got %0d", want.ctls, out_tdata[98:67]);
          mismatch_count++;
        end
        if (out_tdata[103:99] !== 5'd0) begin
          $error("padding: expected 0, got %0d", out_tdata[103:99]);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Sends one byte and returns at the edge where the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buffer(input bytes_t text);
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    buffers_sent++;
  endtask

  // The low n bytes of w, most significant first.
  function automatic bytes_t word_bytes(logic [63:0] w, int n);
    bytes_t q;
    for (int i = n - 1; i >= 0; i--) q.push_back(w[8*i +: 8]);
    return q;
  endfunction

  task automatic test_directed();
    send_buffer(word_bytes({BYTE_FF}, 1));                               // one byte
    send_buffer(word_bytes({BYTE_FE, BYTE_FF}, 2));                      // ucs2 be
    send_buffer(word_bytes({BYTE_FF, BYTE_FE}, 2));                      // ucs2 le
    send_buffer(word_bytes({BYTE_FF, BYTE_FE, BYTE_00, BYTE_00}, 4));    // ucs4 le
    send_buffer(word_bytes({BYTE_00, BYTE_00, BYTE_FE, BYTE_FF}, 4));    // ucs4 be
    send_buffer(word_bytes({BYTE_EF, BYTE_BB, BYTE_BF}, 3));             // utf8 mark
    // A good two-byte sequence, then a three-byte one broken by plain ASCII.
    send_buffer(word_bytes(64'hC3A9E28241, 5));
    // Delete and whitespace, then a four-byte sequence cut off by the end.
    send_buffer(word_bytes(64'h7F0D0A09_20F09F98, 8));
  endtask

  task automatic test_marks(input int budget);
    bytes_t text;
    logic [31:0] mark;
    int len;
    int start;
    int idx;
    int flip_pos;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      case ($urandom_range(7))
        0: begin mark = {BYTE_FE, BYTE_FF}; len = 2; end
        1: begin mark = {BYTE_FE, BYTE_FF, BYTE_00, BYTE_00}; len = 4; end
        2: begin mark = {BYTE_FF, BYTE_FE}; len = 2; end
        3: begin mark = {BYTE_FF, BYTE_FE, BYTE_00, BYTE_00}; len = 4; end
        4: begin mark = {BYTE_00, BYTE_00}; len = 2; end
        5: begin mark = {BYTE_00, BYTE_00, BYTE_FE, BYTE_FF}; len = 4; end
        6: begin mark = {BYTE_EF, BYTE_BB, BYTE_BF}; len = 3; end
        default: begin mark = {BYTE_EF, 16'($urandom_range(16'hFFFF))}; len = 3; end
      endcase
      text = word_bytes({32'd0, mark}, len);
      // Near misses: a flipped bit, or a mark cut short at the end of the buffer.
      if ($urandom_range(3) == 0) begin
        idx = $urandom_range(len - 1);
        flip_pos = $urandom_range(7);
        text[idx][flip_pos] = ~text[idx][flip_pos];
      end
      if ($urandom_range(3) == 0) void'(text.pop_back());
      else repeat ($urandom_range(4)) text.push_back(8'($urandom_range(255)));
      send_buffer(text);
    end
  endtask

  task automatic test_utf8_text(input int budget);
    bytes_t text;
    logic [7:0] lead;
    logic noisy;
    int kind;
    int ncont;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      text.delete();
      noisy = ($urandom_range(3) == 0);
      repeat ($urandom_range(10, 1)) begin
        kind = $urandom_range(9);
        ncont = 0;
        if (kind == 9 && !noisy) kind = 0;
        case (kind)
          0, 1, 2: text.push_back(8'($urandom_range(8'h7E, 8'h20)));
          3: begin
            case ($urandom_range(2))
              0: text.push_back(BYTE_CR);
              1: text.push_back(BYTE_LF);
              default: text.push_back(BYTE_TAB);
            endcase
          end
          4, 5: begin lead = {3'b110, 5'($urandom_range(31))}; ncont = 1; end
          6, 7: begin lead = {4'b1110, 4'($urandom_range(15))}; ncont = 2; end
          8: begin lead = {5'b11110, 3'($urandom_range(7))}; ncont = 3; end
          default: begin
            case ($urandom_range(3))
              0: text.push_back({2'b10, 6'($urandom_range(63))});      // stray continuation
              1: text.push_back($urandom_range(1) ? BYTE_DEL : 8'($urandom_range(31)));
              2: text.push_back(8'($urandom_range(255, 248)));         // never a lead byte
              default: begin
                // Four-byte lead with too few continuation bytes.
                text.push_back({5'b11110, 3'($urandom_range(7))});
                repeat ($urandom_range(2)) text.push_back({2'b10, 6'($urandom_range(63))});
              end
            endcase
          end
        endcase
        if (ncont != 0) begin
          text.push_back(lead);
          repeat (ncont) text.push_back({2'b10, 6'($urandom_range(63))});
        end
      end
      send_buffer(text);
    end
  endtask

  task automatic test_noise(input int budget);
    bytes_t text;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      text.delete();
      repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
      send_buffer(text);
    end
  endtask

  task automatic run_random_mix(input int sender_idle, input int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    test_marks(25);
    test_utf8_text(45);
    test_noise(24);
  endtask

  initial begin
    clear_scan();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'd0;
    in_tlast <= 1'b0;
    out_tready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    run_random_mix(0, 0);
    run_random_mix(65, 0);
    run_random_mix(0, 65);
    run_random_mix(13, 13);
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d bytes in %0d buffers, %0d results checked, %0d mismatches",
             bytes_sent, buffers_sent, results_checked, mismatch_count);
    $display("tb_top: ascii %0d binary %0d utf8 %0d ucs2le %0d ucs2be %0d ucs4le %0d ucs4be %0d",
             enc_seen[0], enc_seen[1], enc_seen[2], enc_seen[3], enc_seen[4], enc_seen[5],
             enc_seen[6]);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: text_encoding_sniffer_unit.f
sv/tes_pkg.sv
sv/tes_scan.sv
sv/tes_decide.sv
sv/text_encoding_sniffer_unit.sv
tb/tb_top.sv
